### hdl/ipem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipem_pkg: shared types and constants for the PCM effect mixer
// Item layouts, queue command and job formats, register indexes and the
// fixed arithmetic constants of the mix path.
// ----------------------------------------------------------------------------
package ipem_pkg;

  // Widths fixed by the item fields and registers.
  localparam int SAMPLE_W   = 8;
  localparam int LEVEL_W    = 16;
  localparam int AUDIO_W    = 16;
  localparam int STEP_W     = 24;
  localparam int VOL_W      = 7;
  localparam int OP_W       = 2;
  localparam int REG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int FRAC_MAX_W = 24;

  // Input op codes.
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_RENDER = 2'd2;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_STEP         = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MUSIC_VOLUME = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_EFFECT_VOLUME = 2'd2;

  localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;
  localparam logic [VOL_W-1:0]  VOL_MAX    = 7'd100;

  // Mix arithmetic: saturation bounds in units of 1/100 of an output step,
  // and the reciprocal used to divide a magnitude by 100.
  localparam int PCT_MAX     = 100;
  localparam int MIX_HI      = 3276700;
  localparam int MIX_LO      = -3276800;
  localparam int MAG_W       = 22;
  localparam int RECIP       = 167772;
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 24;
  localparam int QUO_W       = 16;
  localparam logic signed [AUDIO_W-1:0] AUDIO_MAX = 16'sh7fff;
  localparam logic signed [AUDIO_W-1:0] AUDIO_MIN = -16'sh8000;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic [OP_W-1:0]             op;
    logic [SAMPLE_W-1:0]         sample_byte;
    logic signed [LEVEL_W-1:0]   music_level;
  } in_item_t;

  typedef struct packed {
    logic signed [AUDIO_W-1:0]   audio_sample;
    logic                        effect_playing;
    logic                        saturated;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_APPEND,
    CMD_RENDER
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                     op;
    logic [SAMPLE_W-1:0]         data;
    logic signed [LEVEL_W-1:0]   level;
  } cmd_t;

  // One render job handed from the back engine to the mix pipeline.
  typedef struct packed {
    logic                        valid;
    logic signed [SAMPLE_W-1:0]  a;
    logic signed [SAMPLE_W-1:0]  b;
    logic [FRAC_MAX_W-1:0]       frac;
    logic signed [LEVEL_W-1:0]   level;
    logic                        playing;
  } job_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ_NEXT
  } back_state_t;

endpackage

### hdl/ipem_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipem_queue: command queue
// A small first-in first-out buffer that decouples the front from the back.
// ----------------------------------------------------------------------------
module ipem_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ipem_pkg::cmd_t push_cmd,
  input  logic           pop,
  output ipem_pkg::cmd_t head_cmd,
  output logic           full,
  output logic           empty
);

  ipem_pkg::cmd_t                 slot_r [ipem_pkg::QUEUE_DEPTH];
  logic [ipem_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [ipem_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [ipem_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign full     = (cnt_r == ipem_pkg::QCNT_W'(ipem_pkg::QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_cmd = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### hdl/ipem_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipem_front: input item decoder
// Accepts items, halves appended bytes about the centre and queues commands.
// ----------------------------------------------------------------------------
module ipem_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  ipem_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               q_push,
  output ipem_pkg::cmd_t     q_cmd
);

  // Halve the distance to 128, rounding toward 128.
  function automatic logic [7:0] halve_to_centre(input logic [7:0] s);
    logic [7:0] d;
    begin
      if (s < 8'h80) begin
        d = 8'h80 - s;
        halve_to_centre = 8'h80 - (d >> 1);
      end else begin
        d = s - 8'h80;
        halve_to_centre = 8'h80 + (d >> 1);
      end
    end
  endfunction

  logic accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    q_push      = 1'b0;
    q_cmd.op    = ipem_pkg::CMD_CLEAR;
    q_cmd.data  = halve_to_centre(in_data.sample_byte);
    q_cmd.level = in_data.music_level;
    case (in_data.op)
      ipem_pkg::OP_CLEAR: begin
        q_push   = accept;
        q_cmd.op = ipem_pkg::CMD_CLEAR;
      end
      ipem_pkg::OP_APPEND: begin
        q_push   = accept;
        q_cmd.op = ipem_pkg::CMD_APPEND;
      end
      ipem_pkg::OP_RENDER: begin
        q_push   = accept;
        q_cmd.op = ipem_pkg::CMD_RENDER;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

endmodule

### hdl/ipem_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipem_back: sample store and playback engine
// Executes queued commands, owns the sample memory, the sample count and the
// play position, and fetches both neighbours for each render job.
// ----------------------------------------------------------------------------
module ipem_back #(
  parameter int SAMPLE_DEPTH  = 65536,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ipem_pkg::cmd_t                q_cmd,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  logic                          adv,
  input  logic [ipem_pkg::STEP_W-1:0]   step,
  output ipem_pkg::job_t                job
);

  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam int CW = $clog2(SAMPLE_DEPTH + 1);
  localparam int PW = CW + FRACTION_BITS;
  localparam int SW = ((PW > ipem_pkg::STEP_W) ? PW : ipem_pkg::STEP_W) + 1;

  function automatic logic signed [7:0] centre(input logic [7:0] m);
    centre = signed'({~m[7], m[6:0]});
  endfunction

  logic [7:0]                 sample_store [SAMPLE_DEPTH];
  logic [7:0]                 mem_q;

  ipem_pkg::back_state_t      state_r, state_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [PW-1:0]              pos_r, pos_nxt;

  logic [PW-1:0]              end_w;
  logic [CW-1:0]              k_w, kn_w;
  logic                       active_w, bok_w;
  logic [SW-1:0]              sum_w;

  logic                       wr_en, rd_en, issue, s0_load, play_w;
  logic [AW-1:0]              wr_addr, rd_addr;

  // Job held between the issue cycle and the second read.
  logic                       act_r, bok_r;
  logic [FRACTION_BITS-1:0]   frac_r;
  logic signed [15:0]         level_r;
  logic [AW-1:0]              kn_r;

  // Job stage whose second neighbour arrives on mem_q.
  logic                       s0_valid_r;
  logic signed [7:0]          s0_a_r;
  logic                       s0_bok_r;
  logic [FRACTION_BITS-1:0]   s0_frac_r;
  logic signed [15:0]         s0_level_r;
  logic                       s0_play_r;

  assign end_w    = {count_r, {FRACTION_BITS{1'b0}}};
  assign active_w = (pos_r < end_w);
  assign k_w      = pos_r[PW-1:FRACTION_BITS];
  assign kn_w     = k_w + CW'(1);
  assign bok_w    = (kn_w < count_r);
  assign sum_w    = SW'(pos_r) + SW'(step);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    q_pop     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = count_r[AW-1:0];
    rd_en     = 1'b0;
    rd_addr   = k_w[AW-1:0];
    issue     = 1'b0;
    s0_load   = 1'b0;
    play_w    = 1'b0;
    case (state_r)
      ipem_pkg::BK_IDLE: begin
        if (!q_empty) begin
          case (q_cmd.op)
            ipem_pkg::CMD_CLEAR: begin
              q_pop     = 1'b1;
              count_nxt = '0;
              pos_nxt   = '0;
            end
            ipem_pkg::CMD_APPEND: begin
              q_pop = 1'b1;
              if (count_r < CW'(SAMPLE_DEPTH)) begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            ipem_pkg::CMD_RENDER: begin
              // The read would overwrite a neighbour still waiting in mem_q,
              // so it goes only when the mix path moves.
              if (adv) begin
                q_pop     = 1'b1;
                rd_en     = 1'b1;
                issue     = 1'b1;
                state_nxt = ipem_pkg::BK_READ_NEXT;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ipem_pkg::BK_READ_NEXT: begin
        if (adv) begin
          rd_en     = bok_r;
          rd_addr   = kn_r;
          s0_load   = 1'b1;
          state_nxt = ipem_pkg::BK_IDLE;
          if (act_r) begin
            if (sum_w >= SW'(end_w)) begin
              count_nxt = '0;
              pos_nxt   = '0;
            end else begin
              pos_nxt = sum_w[PW-1:0];
              play_w  = 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ipem_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ipem_pkg::BK_IDLE;
      count_r    <= '0;
      pos_r      <= '0;
      s0_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      if (s0_load) begin
        s0_valid_r <= 1'b1;
      end else if (adv) begin
        s0_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      act_r   <= active_w;
      bok_r   <= active_w && bok_w;
      frac_r  <= pos_r[FRACTION_BITS-1:0];
      level_r <= q_cmd.level;
      kn_r    <= kn_w[AW-1:0];
    end
    if (s0_load) begin
      s0_a_r     <= act_r ? centre(mem_q) : 8'sd0;
      s0_bok_r   <= bok_r;
      s0_frac_r  <= frac_r;
      s0_level_r <= level_r;
      s0_play_r  <= play_w;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sample_store[wr_addr] <= q_cmd.data;
    end
    if (rd_en) begin
      mem_q <= sample_store[rd_addr];
    end
  end

  always_comb begin
    job.valid   = s0_valid_r;
    job.a       = s0_a_r;
    job.b       = s0_bok_r ? centre(mem_q) : 8'sd0;
    job.frac    = ipem_pkg::FRAC_MAX_W'(s0_frac_r);
    job.level   = s0_level_r;
    job.playing = s0_play_r;
  end

endmodule

### hdl/ipem_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipem_mix: interpolation and mix pipeline
// Interpolates, applies both volumes, saturates, divides by 100 toward zero
// and holds the result item in the output register.
// ----------------------------------------------------------------------------
module ipem_mix #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ipem_pkg::job_t               job,
  input  logic [ipem_pkg::VOL_W-1:0]   music_volume,
  input  logic [ipem_pkg::VOL_W-1:0]   effect_volume,
  output logic                         adv,
  output logic                         out_valid,
  input  logic                         out_stall,
  output ipem_pkg::out_item_t          out_data
);

  localparam int F   = FRACTION_BITS;
  localparam int PRW = F + 10;
  localparam int IW  = F + 10;
  localparam int EW  = IW + 8;
  localparam int XW  = F + 27;
  localparam int MW  = ipem_pkg::MAG_W;
  localparam int QW  = ipem_pkg::QUO_W;
  localparam int RPW = MW + ipem_pkg::RECIP_W;
  localparam logic signed [XW-1:0] SAT_HI = XW'(ipem_pkg::MIX_HI) <<< F;
  localparam logic signed [XW-1:0] SAT_LO = XW'(ipem_pkg::MIX_LO) <<< F;

  logic signed [8:0]      d_w;
  logic signed [F:0]      fr_w;
  logic signed [7:0]      mv_w, ev_w;

  logic                   v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;
  logic signed [7:0]      a1_r;
  logic signed [PRW-1:0]  p1_r;
  logic signed [23:0]     lm1_r, lm2_r, lm3_r;
  logic                   pl1_r, pl2_r, pl3_r, pl4_r, pl5_r, pl6_r;
  logic signed [IW-1:0]   i2_r;
  logic signed [EW-1:0]   e3_r;
  logic signed [XW-1:0]   x4_r, xabs_w;
  logic                   hi5_r, lo5_r, neg5_r, hi6_r, lo6_r, neg6_r;
  logic [MW-1:0]          m5_r, m6_r;
  logic [RPW-1:0]         rp_w;
  logic [QW-1:0]          q6_r;
  logic [MW-1:0]          qm_w, r_w;
  logic [QW-1:0]          qf_w;
  logic signed [ipem_pkg::AUDIO_W-1:0] audio_w;
  ipem_pkg::out_item_t    out_r;

  assign adv       = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign d_w  = {job.b[7], job.b} - {job.a[7], job.a};
  assign fr_w = signed'({1'b0, job.frac[F-1:0]});
  assign mv_w = signed'({1'b0, music_volume});
  assign ev_w = signed'({1'b0, effect_volume});

  assign xabs_w = x4_r[XW-1] ? -x4_r : x4_r;
  assign rp_w   = RPW'(m5_r) * RPW'(ipem_pkg::RECIP);

  // The reciprocal quotient is low by at most one; one compare fixes it.
  always_comb begin
    qm_w = MW'(q6_r * ipem_pkg::PCT_MAX);
    r_w  = m6_r - qm_w;
    qf_w = q6_r + QW'(r_w >= MW'(ipem_pkg::PCT_MAX));
    if (hi6_r) begin
      audio_w = ipem_pkg::AUDIO_MAX;
    end else if (lo6_r) begin
      audio_w = ipem_pkg::AUDIO_MIN;
    end else if (neg6_r) begin
      audio_w = signed'(-qf_w);
    end else begin
      audio_w = signed'(qf_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= job.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r   <= job.a;
      p1_r   <= d_w * fr_w;
      lm1_r  <= job.level * mv_w;
      pl1_r  <= job.playing;

      i2_r   <= (IW'(a1_r) <<< F) + IW'(p1_r);
      lm2_r  <= lm1_r;
      pl2_r  <= pl1_r;

      e3_r   <= i2_r * ev_w;
      lm3_r  <= lm2_r;
      pl3_r  <= pl2_r;

      x4_r   <= (XW'(lm3_r) <<< F) + (XW'(e3_r) <<< 8);
      pl4_r  <= pl3_r;

      hi5_r  <= (x4_r > SAT_HI);
      lo5_r  <= (x4_r < SAT_LO);
      neg5_r <= x4_r[XW-1];
      m5_r   <= xabs_w[F +: MW];
      pl5_r  <= pl4_r;

      q6_r   <= rp_w[ipem_pkg::RECIP_SHIFT +: QW];
      m6_r   <= m5_r;
      hi6_r  <= hi5_r;
      lo6_r  <= lo5_r;
      neg6_r <= neg5_r;
      pl6_r  <= pl5_r;

      out_r.audio_sample   <= audio_w;
      out_r.effect_playing <= pl6_r;
      out_r.saturated      <= hi6_r || lo6_r;
    end
  end

endmodule

### hdl/interpolating_pcm_effect_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interpolating_pcm_effect_mixer: one-shot PCM effect mixed into music
// Top level with the configuration registers, the front decoder, the command
// queue, the playback engine and the mix pipeline.
// ----------------------------------------------------------------------------
// Usage. Items enter on in_valid/in_stall/in_data. A clear item stops the
// effect and empties the store, an append item adds one byte to the effect,
// and a render item produces exactly one result item on out_valid/out_stall/
// out_data; an item with the unused op code is taken and dropped.
// Configuration is written through cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high; writes are to be made only while the block is
// idle, and the block itself does not enforce this. A clear or append item
// is handled in the BK_IDLE state alone. A render item passes through
// BK_IDLE and then BK_READ_NEXT, one for each read of the single read port
// of the sample memory; no new command is taken until both are done.
// The queue between the decoder and the engine holds four commands, so the
// input keeps taking items while the engine or the output waits.
// Reset clears the sample count, play position, queue and pipeline valids
// and restores the register defaults; the sample memory is not cleared.
// When the receiver stalls, the output register holds its item, the whole
// mix pipeline freezes, and new items pile up in the queue until in_stall.
// ----------------------------------------------------------------------------
module interpolating_pcm_effect_mixer #(
  parameter int SAMPLE_DEPTH  = 65536,
  parameter int FRACTION_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ipem_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ipem_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ipem_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [ipem_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [ipem_pkg::STEP_W-1:0] step_r;
  logic [ipem_pkg::VOL_W-1:0]  music_vol_r;
  logic [ipem_pkg::VOL_W-1:0]  effect_vol_r;
  logic [ipem_pkg::VOL_W-1:0]  vol_w;

  logic           q_push, q_pop, q_full, q_empty, adv;
  ipem_pkg::cmd_t push_cmd, head_cmd;
  ipem_pkg::job_t job;

  assign cfg_ready = 1'b1;

  // Volumes above 100 percent are limited to 100.
  assign vol_w = (cfg_data[ipem_pkg::VOL_W-1:0] > ipem_pkg::VOL_MAX) ?
                 ipem_pkg::VOL_MAX : cfg_data[ipem_pkg::VOL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= ipem_pkg::STEP_RESET;
      music_vol_r  <= ipem_pkg::VOL_MAX;
      effect_vol_r <= ipem_pkg::VOL_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ipem_pkg::REG_STEP: begin
          step_r <= cfg_data[ipem_pkg::STEP_W-1:0];
        end
        ipem_pkg::REG_MUSIC_VOLUME: begin
          music_vol_r <= vol_w;
        end
        ipem_pkg::REG_EFFECT_VOLUME: begin
          effect_vol_r <= vol_w;
        end
        default: begin
          // Writes to unknown registers are ignored.
        end
      endcase
    end
  end

  ipem_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  ipem_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  ipem_back #(
    .SAMPLE_DEPTH  (SAMPLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_cmd   (head_cmd),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .adv     (adv),
    .step    (step_r),
    .job     (job)
  );

  ipem_mix #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mix (
    .clk           (clk),
    .rst_n         (rst_n),
    .job           (job),
    .music_volume  (music_vol_r),
    .effect_volume (effect_vol_r),
    .adv           (adv),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the interpolating PCM effect mixer
// Drives clear, append and render items through the stall handshake,
// predicts every frame with an in-bench mixer model, and compares each
// output item field by field, under several register settings and idling.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SAMPLE_DEPTH  = 65536;
  localparam int FRACTION_BITS = 16;
  localparam longint FRAC_ONE  = longint'(1) << FRACTION_BITS;
  // Divisor that turns the scaled mix numerator back into output steps.
  localparam longint MIX_DIV   = 100 * FRAC_ONE;
  // Cycles allowed after the last frame for clears and appends still inside.
  localparam int TAIL_CYCLES   = 32;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 124;

  // Codes that the package leaves unnamed but the bench has to send.
  localparam logic [ipem_pkg::OP_W-1:0]      OP_UNUSED  = 2'd3;
  localparam logic [ipem_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  ipem_pkg::in_item_t              in_data   = '0;
  logic                            out_stall = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic [ipem_pkg::REG_IDX_W-1:0]  cfg_index = '0;
  logic [ipem_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                            in_stall;
  logic                            out_valid;
  ipem_pkg::out_item_t             out_data;
  logic                            cfg_ready;

  interpolating_pcm_effect_mixer #(
    .SAMPLE_DEPTH  (SAMPLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The bench's own copy of the effect player: stored samples, length and
  // fixed-point play position, plus the register values it has written.
  logic [ipem_pkg::SAMPLE_W-1:0] voice_mem [0:SAMPLE_DEPTH-1];
  int                  voice_len  = 0;
  longint              voice_pos  = 0;
  longint              mix_step   = longint'(ipem_pkg::STEP_RESET);
  longint              music_gain = 100;
  longint              fx_gain    = 100;

  // Frames predicted but not yet seen on the output, oldest first.
  ipem_pkg::out_item_t frame_expect_q[$];

  // Percentages of cycles in which the sender and the receiver hold back.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int error_count   = 0;
  int items_sent    = 0;
  int frames_seen   = 0;
  int clamped_seen  = 0;
  int reg_writes    = 0;

  // Directed stimulus: one row per item. A row marked as typed carries the
  // frame read straight off the behavior; the rest lean on the predictor.
  typedef struct packed {
    ipem_pkg::in_item_t  item;
    logic                typed;
    ipem_pkg::out_item_t frame;
  } stim_row_t;

  stim_row_t directed_rows[$];

  // Bytes are pulled halfway toward the 0x80 centre, rounding toward it.
  function automatic logic [ipem_pkg::SAMPLE_W-1:0] halve_about_centre(
      input logic [ipem_pkg::SAMPLE_W-1:0] s);
    if (s < 8'h80) return 8'h80 - ((8'h80 - s) >> 1);
    if (s > 8'h80) return ((s - 8'h80) >> 1) + 8'h80;
    return s;
  endfunction

  // Only the low seven bits of a volume write count, and anything above
  // full scale is treated as full scale.
  function automatic longint clamp_percent(input logic [ipem_pkg::CFG_DATA_W-1:0] value);
    logic [ipem_pkg::VOL_W-1:0] low7;
    low7 = value[ipem_pkg::VOL_W-1:0];
    return (low7 > ipem_pkg::VOL_MAX) ? longint'(ipem_pkg::VOL_MAX) : longint'(low7);
  endfunction

  // Advances the player model by one accepted item. Renders hand back the
  // frame the block must produce; everything else produces nothing.
  function automatic void mix_item(input ipem_pkg::in_item_t it, output bit produced,
                                   output ipem_pkg::out_item_t frame);
    longint level;
    longint num;
    longint end_pos;
    longint idx;
    longint frac;
    longint a;
    longint b;
    longint interp;
    longint quot;
    bit     clamped;
    produced = 1'b0;
    frame    = '0;
    case (it.op)
      ipem_pkg::OP_CLEAR: begin
        voice_len = 0;
        voice_pos = 0;
      end
      ipem_pkg::OP_APPEND: begin
        // A full store silently drops further appends.
        if (voice_len < SAMPLE_DEPTH) begin
          voice_mem[voice_len] = halve_about_centre(it.sample_byte);
          voice_len++;
        end
      end
      ipem_pkg::OP_RENDER: begin
        level   = longint'($signed(it.music_level));
        num     = level * music_gain * FRAC_ONE;
        end_pos = longint'(voice_len) << FRACTION_BITS;
        clamped = 1'b0;
        if (voice_pos < end_pos) begin
          idx    = voice_pos >>> FRACTION_BITS;
          frac   = voice_pos & (FRAC_ONE - 1);
          a      = longint'(voice_mem[idx]) - 128;
          // Past the last stored sample the next neighbour is silence.
          b      = (idx + 1 < voice_len) ? longint'(voice_mem[idx + 1]) - 128 : 0;
          interp = a * FRAC_ONE + (b - a) * frac;
          num    = num + interp * 256 * fx_gain;
          voice_pos = voice_pos + mix_step;
          if (voice_pos >= end_pos) begin
            voice_len = 0;
            voice_pos = 0;
          end
        end
        if (num > longint'(32767) * MIX_DIV) begin
          quot    = 32767;
          clamped = 1'b1;
        end else if (num < longint'(-32768) * MIX_DIV) begin
          quot    = -32768;
          clamped = 1'b1;
        end else begin
          quot = num / MIX_DIV;
        end
        frame.audio_sample   = quot[ipem_pkg::AUDIO_W-1:0];
        frame.effect_playing = voice_pos < (longint'(voice_len) << FRACTION_BITS);
        frame.saturated      = clamped;
        produced = 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void add_row(input logic [ipem_pkg::OP_W-1:0] op,
                                  input logic [ipem_pkg::SAMPLE_W-1:0] sb,
                                  input logic [ipem_pkg::LEVEL_W-1:0] lvl,
                                  input logic typed,
                                  input logic [ipem_pkg::AUDIO_W-1:0] audio,
                                  input logic playing,
                                  input logic clamped);
    stim_row_t row;
    row.item.op                = op;
    row.item.sample_byte       = sb;
    row.item.music_level       = lvl;
    row.typed                  = typed;
    row.frame.audio_sample     = audio;
    row.frame.effect_playing   = playing;
    row.frame.saturated        = clamped;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Random item with the given op. Every field is randomized whatever the op,
  // leaning toward the extremes and centre of the byte and of the music level.
  function automatic ipem_pkg::in_item_t rand_item(input logic [ipem_pkg::OP_W-1:0] op);
    ipem_pkg::in_item_t it;
    it.op = op;
    case ($urandom_range(0, 5))
      0:       it.sample_byte = 8'h00;
      1:       it.sample_byte = 8'hFF;
      2:       it.sample_byte = 8'h7F + 8'($urandom_range(0, 2));
      default: it.sample_byte = 8'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       it.music_level = 16'h7FFF;
      1:       it.music_level = 16'h8000;
      2:       it.music_level = 16'($urandom_range(0, 600)) - 16'd300;
      default: it.music_level = 16'($urandom);
    endcase
    return it;
  endfunction

  // Presents one item after an optional random gap and holds it until the
  // block takes it. The valid stays high on return, so a following item
  // can go out back to back; any caller that stops sending lowers it.
  task automatic send_item(input ipem_pkg::in_item_t it, input logic typed,
                           input ipem_pkg::out_item_t typed_frame);
    bit                  produced;
    ipem_pkg::out_item_t frame;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mix_item(it, produced, frame);
    if (produced) frame_expect_q.insert(frame_expect_q.size(), typed ? typed_frame : frame);
    if (it.op != OP_UNUSED) items_sent++;
  endtask

  // Stops sending and waits until every predicted frame has come back,
  // then lets extra cycles pass so queued clears and appends settle.
  task automatic wait_drained(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_expect_q.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // One register write. The valid is left high so writes can follow each
  // other; configure() lowers it once the group is done.
  task automatic write_reg(input logic [ipem_pkg::REG_IDX_W-1:0] idx,
                           input logic [ipem_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ipem_pkg::REG_STEP:          mix_step   = longint'(value);
      ipem_pkg::REG_MUSIC_VOLUME:  music_gain = clamp_percent(value);
      ipem_pkg::REG_EFFECT_VOLUME: fx_gain    = clamp_percent(value);
      default: begin
        // An unknown index is accepted and changes nothing.
      end
    endcase
    reg_writes++;
  endtask

  task automatic configure(input logic [ipem_pkg::CFG_DATA_W-1:0] step,
                           input logic [ipem_pkg::CFG_DATA_W-1:0] mvol,
                           input logic [ipem_pkg::CFG_DATA_W-1:0] evol,
                           input bit poke_unused);
    write_reg(ipem_pkg::REG_STEP, step);
    write_reg(ipem_pkg::REG_MUSIC_VOLUME, mvol);
    write_reg(ipem_pkg::REG_EFFECT_VOLUME, evol);
    if (poke_unused) write_reg(REG_UNUSED, ipem_pkg::CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic. Most of it is the normal use pattern: maybe a clear,
  // a burst of appended bytes, then a run of frames that play them out,
  // often with appends landing while the effect still plays. The rest is
  // loose noise with any op code, the unused one included.
  task automatic run_random(input int count);
    int start;
    int burst;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(0, 99) < 72) begin
        if ($urandom_range(0, 3) == 0) send_item(rand_item(ipem_pkg::OP_CLEAR), 1'b0, '0);
        burst = $urandom_range(1, 12);
        repeat (burst) send_item(rand_item(ipem_pkg::OP_APPEND), 1'b0, '0);
        burst = $urandom_range(1, 16);
        repeat (burst) send_item(rand_item(ipem_pkg::OP_RENDER), 1'b0, '0);
      end else begin
        burst = $urandom_range(1, 4);
        repeat (burst) send_item(rand_item(ipem_pkg::OP_W'($urandom_range(0, 3))), 1'b0, '0);
      end
    end
  endtask

  // Output side: a random stall each cycle, and every frame taken is
  // checked against the oldest prediction.
  always @(posedge clk) begin : frame_check
    ipem_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      frames_seen++;
      if (out_data.saturated) clamped_seen++;
      if (frame_expect_q.size() == 0) begin
        error_count++;
        $display("%0t ns: frame with none expected, got sample %0d playing %0b saturated %0b",
                 $time, $signed(out_data.audio_sample), out_data.effect_playing,
                 out_data.saturated);
      end else begin
        want = frame_expect_q.pop_front();
        if (out_data.audio_sample !== want.audio_sample) begin
          error_count++;
          $display("%0t ns: audio_sample expected %0d, got %0d", $time,
                   $signed(want.audio_sample), $signed(out_data.audio_sample));
        end
        if (out_data.effect_playing !== want.effect_playing) begin
          error_count++;
          $display("%0t ns: effect_playing expected %0b, got %0b", $time,
                   want.effect_playing, out_data.effect_playing);
        end
        if (out_data.saturated !== want.saturated) begin
          error_count++;
          $display("%0t ns: saturated expected %0b, got %0b", $time,
                   want.saturated, out_data.saturated);
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #4000000;
    $display("FAIL interpolating_pcm_effect_mixer");
    $finish;
  end

  initial begin : stimulus
    int ri;
    int p;
    int tail_bytes;

    // Directed rows, run at the reset register values. With no effect
    // loaded a frame is the music level itself, so the first ones can be
    // typed in; the interpolated ones are left to the predictor.
    add_row(ipem_pkg::OP_RENDER, 8'h00, 16'h7FFF, 1'b1, 16'h7FFF, 1'b0, 1'b0);
    add_row(ipem_pkg::OP_RENDER, 8'hFF, 16'h8000, 1'b1, 16'h8000, 1'b0, 1'b0);
    add_row(ipem_pkg::OP_RENDER, 8'hFF, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0);
    // The unused op code is taken and produces nothing.
    add_row(OP_UNUSED, 8'hFF, 16'h7FFF, 1'b0, '0, 1'b0, 1'b0);
    // Bytes at both ends and around the centre, to exercise the halving.
    add_row(ipem_pkg::OP_APPEND, 8'h00, 16'h8000, 1'b0, '0, 1'b0, 1'b0);
    add_row(ipem_pkg::OP_APPEND, 8'hFF, 16'hFFFF, 1'b0, '0, 1'b0, 1'b0);
    add_row(ipem_pkg::OP_APPEND, 8'h80, 16'h0000, 1'b0, '0, 1'b0, 1'b0);
    add_row(ipem_pkg::OP_APPEND, 8'h7F, 16'h7FFF, 1'b0, '0, 1'b0, 1'b0);
    add_row(ipem_pkg::OP_APPEND, 8'h81, 16'h1234, 1'b0, '0, 1'b0, 1'b0);
    add_row(ipem_pkg::OP_RENDER, 8'h55, 16'h7FFF, 1'b0, '0, 1'b0, 1'b0);
    add_row(ipem_pkg::OP_RENDER, 8'hAA, 16'h8000, 1'b0, '0, 1'b0, 1'b0);
    // An append while the effect is still playing extends it.
    add_row(ipem_pkg::OP_APPEND, 8'h01, 16'h5555, 1'b0, '0, 1'b0, 1'b0);
    add_row(ipem_pkg::OP_RENDER, 8'h00, 16'h1234, 1'b0, '0, 1'b0, 1'b0);
    add_row(ipem_pkg::OP_RENDER, 8'hFF, 16'hEDCB, 1'b0, '0, 1'b0, 1'b0);
    // After a clear the music passes through alone again.
    add_row(ipem_pkg::OP_CLEAR,  8'hFF, 16'hFFFF, 1'b0, '0, 1'b0, 1'b0);
    add_row(ipem_pkg::OP_RENDER, 8'h00, 16'd100,  1'b1, 16'd100, 1'b0, 1'b0);
    // Two loud bytes on top of full-scale music clip high and keep playing.
    add_row(ipem_pkg::OP_APPEND, 8'hFF, 16'h0000, 1'b0, '0, 1'b0, 1'b0);
    add_row(ipem_pkg::OP_APPEND, 8'hFF, 16'h0000, 1'b0, '0, 1'b0, 1'b0);
    add_row(ipem_pkg::OP_RENDER, 8'h00, 16'h7FFF, 1'b1, 16'h7FFF, 1'b1, 1'b1);
    // A single low byte under full negative music clips low, and that one
    // frame reaches the end, so the effect stops.
    add_row(ipem_pkg::OP_CLEAR,  8'h00, 16'h0000, 1'b0, '0, 1'b0, 1'b0);
    add_row(ipem_pkg::OP_APPEND, 8'h00, 16'h0000, 1'b0, '0, 1'b0, 1'b0);
    add_row(ipem_pkg::OP_RENDER, 8'hFF, 16'h8000, 1'b1, 16'h8000, 1'b0, 1'b1);
    add_row(ipem_pkg::OP_RENDER, 8'h00, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0);

    // Synchronous reset, held low at the start and then released.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 31;
    recv_idle_pct = 54;
    for (ri = 0; ri < directed_rows.size(); ri++)
      send_item(directed_rows[ri].item, directed_rows[ri].typed, directed_rows[ri].frame);

    // Random phases, each under its own register setting. The first four
    // keep the idling of the directed part, the next three swap the two
    // sides, and the last three run without any idling.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained(TAIL_CYCLES);
      if (p < 4) begin
        send_idle_pct = 31;
        recv_idle_pct = 54;
      end else if (p < 7) begin
        send_idle_pct = 54;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: configure(ipem_pkg::STEP_RESET, ipem_pkg::VOL_MAX, ipem_pkg::VOL_MAX, 1'b1);
        // A zero step holds the position, so the effect never runs out;
        // a volume of 127 is treated as full scale.
        1: configure(24'd0, 24'd0, 24'd127, 1'b0);
        2: configure(24'hFFFFFF, 24'd101, 24'd0, 1'b1);
        // Upper data bits of a volume write are ignored.
        3: configure(24'd1, 24'hFFFFFF, 24'd55, 1'b0);
        default: begin
          case ($urandom_range(0, 3))
            0: configure(ipem_pkg::CFG_DATA_W'($urandom_range(0, 65536)),
                         ipem_pkg::CFG_DATA_W'($urandom),
                         ipem_pkg::CFG_DATA_W'($urandom_range(0, 127)), p[0]);
            1: configure(ipem_pkg::CFG_DATA_W'($urandom_range(65536, 262144)),
                         ipem_pkg::CFG_DATA_W'($urandom_range(0, 127)),
                         ipem_pkg::CFG_DATA_W'($urandom), p[0]);
            2: configure(ipem_pkg::CFG_DATA_W'($urandom),
                         ipem_pkg::CFG_DATA_W'($urandom_range(0, 127)),
                         ipem_pkg::CFG_DATA_W'($urandom_range(0, 127)), p[0]);
            default: configure(ipem_pkg::CFG_DATA_W'($urandom_range(1, 3) * 32768),
                               ipem_pkg::CFG_DATA_W'($urandom_range(90, 127)),
                               ipem_pkg::CFG_DATA_W'($urandom_range(90, 127)), p[0]);
          endcase
        end
      endcase
      run_random(PHASE_ITEMS / 2);
      // Once, the sender holds off mid-phase until every frame is back.
      if (p == 5) wait_drained(0);
      run_random(PHASE_ITEMS / 2);
    end

    // A short effect at the largest step: a single frame runs past its end
    // and stops the effect.
    wait_drained(TAIL_CYCLES);
    configure(24'hFFFFFF, ipem_pkg::CFG_DATA_W'($urandom_range(0, 100)),
              ipem_pkg::VOL_MAX, 1'b0);
    send_item(rand_item(ipem_pkg::OP_CLEAR), 1'b0, '0);
    tail_bytes = $urandom_range(1, 8);
    repeat (tail_bytes) send_item(rand_item(ipem_pkg::OP_APPEND), 1'b0, '0);
    send_item(rand_item(ipem_pkg::OP_RENDER), 1'b0, '0);
    while (voice_len != 0) send_item(rand_item(ipem_pkg::OP_RENDER), 1'b0, '0);

    wait_drained(TAIL_CYCLES);
    $display("Run covered %0d items and %0d checked frames (%0d clipped),",
             items_sent, frames_seen, clamped_seen);
    $display("with %0d register writes and a last effect of %0d bytes at the largest step.",
             reg_writes, tail_bytes);
    if (error_count == 0) begin
      $display("PASS interpolating_pcm_effect_mixer");
    end else begin
      $display("FAIL interpolating_pcm_effect_mixer");
    end
    $finish;
  end

endmodule
